>>> hw/rtl/scaled_sigmoid_rate_unit_macros.svh
// ----------------------------------------------------------------------------
// Scaled sigmoid rate unit assertion macros
// Concurrent assertion helpers used by the top-level RTL, compiled out under SYNTH.
// ----------------------------------------------------------------------------
`ifndef SCALED_SIGMOID_RATE_UNIT_MACROS_SVH
`define SCALED_SIGMOID_RATE_UNIT_MACROS_SVH

`ifndef SYNTH
`define SSR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define SSR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SSR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define SSR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

>>> hw/rtl/ssr_pkg.sv
// ----------------------------------------------------------------------------
// Scaled sigmoid rate package
// Widths, constants and transfer types shared by the sigmoid pipeline.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int DATA_W    = 16;
  localparam int FRAC_W    = 8;
  localparam int NUM_W     = 2 * DATA_W + 1;
  localparam int Q_FRAC    = 32;
  localparam int INT_STEPS = 5;
  localparam int QUO_W     = Q_FRAC + INT_STEPS;
  localparam int U_W       = QUO_W + 1;
  localparam int K_W       = INT_STEPS + 1;
  localparam int S_W       = Q_FRAC + 1;
  localparam int TERMS     = 14;
  localparam int CFG_IDX_W = 1;

  localparam logic [Q_FRAC-1:0] LN2_Q = 32'd2977044472;

  // Floor of 2**32 / n; the entry for n = 1 is one short of 2**32.
  localparam logic [Q_FRAC-1:0] RECIP [1:TERMS] = '{
    32'd4294967295, 32'd2147483648, 32'd1431655765, 32'd1073741824,
    32'd858993459,  32'd715827882,  32'd613566756,  32'd536870912,
    32'd477218588,  32'd429496729,  32'd390451572,  32'd357913941,
    32'd330382099,  32'd306783378
  };

  localparam int EXPO_LAT = 2 + QUO_W;
  localparam int EXP_LAT  = 2 + K_W + 3 * TERMS;
  localparam int NORM_LAT = 3 + DATA_W;
  localparam int LATENCY  = EXPO_LAT + EXP_LAT + NORM_LAT;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_OUTPUT = 1'b0,
    REG_SLOPE_GAIN = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_in;
    logic                     last_in;
  } ssr_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] rate_out;
    logic              last_out;
  } ssr_out_t;

  typedef struct packed {
    logic              last;
    logic              zero;
    logic              neg;
    logic [DATA_W-1:0] m;
  } ssr_side_t;

  typedef struct packed {
    logic [Q_FRAC-1:0] r;
    logic [K_W-1:0]    k;
    ssr_side_t         side;
  } ssr_carry_t;

endpackage

>>> hw/rtl/scaled_sigmoid_rate_unit.sv
// ----------------------------------------------------------------------------
// Scaled sigmoid rate unit
// Streaming y = M / (1 + exp(alpha*(1/2 - x/M))) on Q8.8 samples.
// ----------------------------------------------------------------------------
// The unit takes one sample in every clock cycle and never raises busy. Each
// result appears on out_data with out_valid high for a single cycle, in input
// order; the receiver cannot hold it off. The pipeline is made of the 37-step
// exponent division, the 14-term exponential series at three stages per term
// and the 16-step output division. Write max_output and slope_gain only while
// no sample is in flight.
module scaled_sigmoid_rate_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ssr_pkg::ssr_in_t              in_data,
  output logic                          out_valid,
  output ssr_pkg::ssr_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssr_pkg::DATA_W-1:0]    cfg_wdata
);
  import ssr_pkg::*;
  `include "scaled_sigmoid_rate_unit_macros.svh"

  logic [DATA_W-1:0] max_output_r;
  logic [DATA_W-1:0] slope_gain_r;
  logic              in_xfer;
  logic              x_valid;
  logic [U_W-1:0]    x_mag;
  ssr_side_t         x_side;
  logic              e_valid;
  logic [S_W-1:0]    e_s;
  logic [K_W-1:0]    e_k;
  ssr_side_t         e_side;

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_output_r <= DATA_W'(1) << FRAC_W;
      slope_gain_r <= DATA_W'(1) << FRAC_W;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_OUTPUT: max_output_r <= cfg_wdata;
        REG_SLOPE_GAIN: slope_gain_r <= cfg_wdata;
      endcase
    end
  end

  ssr_expo u_expo (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_xfer),
    .in_item    (in_data),
    .max_output (max_output_r),
    .slope_gain (slope_gain_r),
    .out_valid  (x_valid),
    .out_mag    (x_mag),
    .out_side   (x_side)
  );

  ssr_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (x_valid),
    .in_mag    (x_mag),
    .in_side   (x_side),
    .out_valid (e_valid),
    .out_s     (e_s),
    .out_k     (e_k),
    .out_side  (e_side)
  );

  ssr_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e_valid),
    .in_s      (e_s),
    .in_k      (e_k),
    .in_side   (e_side),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

  `SSR_ASSERT_IMP(a_out_after_latency, clk, rst_n, out_valid,
                  $past(in_xfer, LATENCY))
  `SSR_ASSERT_IMP(a_last_carried, clk, rst_n, out_valid,
                  out_data.last_out == $past(in_data.last_in, LATENCY))
  `SSR_ASSERT_NXT(a_cfg_max_write, clk, rst_n,
                  rst_n && cfg_we && cfg_index == REG_MAX_OUTPUT,
                  max_output_r == $past(cfg_wdata))

endmodule

>>> hw/rtl/ssr_expo.sv
// ----------------------------------------------------------------------------
// Sigmoid exponent magnitude
// Forms |alpha*(1/2 - x/M)| in unsigned Q.32 by a pipelined long division.
// ----------------------------------------------------------------------------
module ssr_expo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  ssr_pkg::ssr_in_t           in_item,
  input  logic [ssr_pkg::DATA_W-1:0] max_output,
  input  logic [ssr_pkg::DATA_W-1:0] slope_gain,
  output logic                       out_valid,
  output logic [ssr_pkg::U_W-1:0]    out_mag,
  output ssr_pkg::ssr_side_t         out_side
);
  import ssr_pkg::*;

  localparam int D_W = DATA_W + 2;
  localparam int RW  = NUM_W + 1;

  logic [D_W-1:0]    diff_raw;
  logic [D_W-1:0]    dmag;
  logic [DATA_W-1:0] amag;
  logic [NUM_W-1:0]  num_nxt;
  ssr_side_t         side_nxt;
  logic [RW-1:0]     sat_lim;

  logic              v0_r;
  logic [NUM_W-1:0]  num0_r;
  ssr_side_t         side0_r;

  logic              v_r     [0:QUO_W];
  logic [RW-1:0]     rem_r   [0:QUO_W];
  logic [QUO_W-1:0]  quo_r   [0:QUO_W];
  logic              sat_r   [0:QUO_W];
  ssr_side_t         side_r  [0:QUO_W];
  logic [RW-1:0]     rem_nxt [0:QUO_W-1];
  logic              take    [0:QUO_W-1];

  assign diff_raw = {2'b00, max_output}
                  - {in_item.sample_in[DATA_W-1], in_item.sample_in, 1'b0};
  assign dmag     = diff_raw[D_W-1] ? (-diff_raw) : diff_raw;
  assign amag     = slope_gain[DATA_W-1] ? (-slope_gain) : slope_gain;
  assign num_nxt  = NUM_W'(amag) * NUM_W'(dmag);

  always_comb begin
    side_nxt.last = in_item.last_in;
    side_nxt.zero = (max_output == '0);
    side_nxt.neg  = (slope_gain[DATA_W-1] ^ diff_raw[D_W-1]) &&
                    (amag != '0) && (dmag != '0);
    side_nxt.m    = max_output;
  end

  assign sat_lim = RW'({side0_r.m, {(FRAC_W + 1 + INT_STEPS){1'b0}}});

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    localparam int SH = (j < INT_STEPS) ? (INT_STEPS - 1 - j) : 0;
    logic [RW-1:0] part;
    logic [RW-1:0] dvs;
    assign part       = (j < INT_STEPS) ? rem_r[j] : (rem_r[j] << 1);
    assign dvs        = RW'({side_r[j].m, {(FRAC_W + 1){1'b0}}}) << SH;
    assign take[j]    = (part >= dvs);
    assign rem_nxt[j] = take[j] ? (part - dvs) : part;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      for (int i = 0; i <= QUO_W; i++) v_r[i] <= 1'b0;
    end else begin
      v0_r   <= in_valid;
      v_r[0] <= v0_r;
      for (int i = 0; i < QUO_W; i++) v_r[i + 1] <= v_r[i];
    end
    num0_r    <= num_nxt;
    side0_r   <= side_nxt;
    rem_r[0]  <= RW'(num0_r);
    quo_r[0]  <= '0;
    sat_r[0]  <= (RW'(num0_r) >= sat_lim);
    side_r[0] <= side0_r;
    for (int i = 0; i < QUO_W; i++) begin
      rem_r[i + 1]  <= rem_nxt[i];
      quo_r[i + 1]  <= {quo_r[i][QUO_W-2:0], take[i]};
      sat_r[i + 1]  <= sat_r[i];
      side_r[i + 1] <= side_r[i];
    end
  end

  assign out_valid = v_r[QUO_W];
  assign out_mag   = sat_r[QUO_W] ? (U_W'(1) << QUO_W) : {1'b0, quo_r[QUO_W]};
  assign out_side  = side_r[QUO_W];

endmodule

>>> hw/rtl/ssr_exp.sv
// ----------------------------------------------------------------------------
// Sigmoid negative exponential
// Reduces the argument by ln2 and runs a pipelined 14-term Horner series.
// ----------------------------------------------------------------------------
module ssr_exp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [ssr_pkg::U_W-1:0]   in_mag,
  input  ssr_pkg::ssr_side_t        in_side,
  output logic                      out_valid,
  output logic [ssr_pkg::S_W-1:0]   out_s,
  output logic [ssr_pkg::K_W-1:0]   out_k,
  output ssr_pkg::ssr_side_t        out_side
);
  import ssr_pkg::*;

  localparam int PR_W = Q_FRAC + S_W;
  localparam int N_W  = $clog2(TERMS + 1);
  localparam int RM_W = Q_FRAC + N_W;
  localparam logic [S_W-1:0] S_ONE = S_W'(1) << Q_FRAC;

  logic              ev_r   [0:K_W];
  logic [U_W-1:0]    rr_r   [0:K_W];
  logic [K_W-1:0]    kk_r   [0:K_W];
  ssr_side_t         es_r   [0:K_W];
  logic [U_W-1:0]    rr_nxt [0:K_W-1];
  logic              rtake  [0:K_W-1];

  logic              hv_r   [0:TERMS];
  logic [S_W-1:0]    hs_r   [0:TERMS];
  ssr_carry_t        hc_r   [0:TERMS];
  logic              av_r   [0:TERMS-1];
  logic [PR_W-1:0]   ap_r   [0:TERMS-1];
  ssr_carry_t        ac_r   [0:TERMS-1];
  logic              bv_r   [0:TERMS-1];
  logic [Q_FRAC-1:0] bt_r   [0:TERMS-1];
  logic [Q_FRAC-1:0] bq_r   [0:TERMS-1];
  ssr_carry_t        bc_r   [0:TERMS-1];
  logic [PR_W-1:0]   ap_nxt [0:TERMS-1];
  logic [Q_FRAC-1:0] bt_nxt [0:TERMS-1];
  logic [Q_FRAC-1:0] bq_nxt [0:TERMS-1];
  logic [S_W-1:0]    hs_nxt [0:TERMS-1];
  ssr_carry_t        load_nxt;

  for (genvar j = 0; j < K_W; j++) begin : g_red
    logic [U_W-1:0] dvs;
    assign dvs       = U_W'(LN2_Q) << (K_W - 1 - j);
    assign rtake[j]  = (rr_r[j] >= dvs);
    assign rr_nxt[j] = rtake[j] ? (rr_r[j] - dvs) : rr_r[j];
  end

  always_comb begin
    load_nxt.r    = rr_r[K_W][Q_FRAC-1:0];
    load_nxt.k    = kk_r[K_W];
    load_nxt.side = es_r[K_W];
  end

  for (genvar t = 0; t < TERMS; t++) begin : g_term
    localparam int N = TERMS - t;
    logic [2*Q_FRAC-1:0] qprod;
    logic [RM_W-1:0]     rem;
    logic [Q_FRAC-1:0]   q;
    assign ap_nxt[t] = PR_W'(hc_r[t].r) * PR_W'(hs_r[t]);
    assign bt_nxt[t] = ap_r[t][Q_FRAC +: Q_FRAC];
    assign qprod     = (2 * Q_FRAC)'(bt_nxt[t]) * (2 * Q_FRAC)'(RECIP[N]);
    assign bq_nxt[t] = qprod[Q_FRAC +: Q_FRAC];
    assign rem       = RM_W'(bt_r[t]) - RM_W'(bq_r[t]) * RM_W'(N);
    assign q         = bq_r[t] + Q_FRAC'(rem >= RM_W'(N));
    assign hs_nxt[t] = S_ONE - S_W'(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= K_W; i++) ev_r[i] <= 1'b0;
      for (int i = 0; i <= TERMS; i++) hv_r[i] <= 1'b0;
      for (int i = 0; i < TERMS; i++) begin
        av_r[i] <= 1'b0;
        bv_r[i] <= 1'b0;
      end
    end else begin
      ev_r[0] <= in_valid;
      for (int i = 0; i < K_W; i++) ev_r[i + 1] <= ev_r[i];
      hv_r[0] <= ev_r[K_W];
      for (int i = 0; i < TERMS; i++) begin
        av_r[i]     <= hv_r[i];
        bv_r[i]     <= av_r[i];
        hv_r[i + 1] <= bv_r[i];
      end
    end
    rr_r[0] <= in_mag;
    kk_r[0] <= '0;
    es_r[0] <= in_side;
    for (int i = 0; i < K_W; i++) begin
      rr_r[i + 1] <= rr_nxt[i];
      kk_r[i + 1] <= {kk_r[i][K_W-2:0], rtake[i]};
      es_r[i + 1] <= es_r[i];
    end
    hs_r[0] <= S_ONE;
    hc_r[0] <= load_nxt;
    for (int i = 0; i < TERMS; i++) begin
      ap_r[i]     <= ap_nxt[i];
      ac_r[i]     <= hc_r[i];
      bt_r[i]     <= bt_nxt[i];
      bq_r[i]     <= bq_nxt[i];
      bc_r[i]     <= ac_r[i];
      hs_r[i + 1] <= hs_nxt[i];
      hc_r[i + 1] <= bc_r[i];
    end
  end

  assign out_valid = hv_r[TERMS];
  assign out_s     = hs_r[TERMS];
  assign out_k     = hc_r[TERMS].k;
  assign out_side  = hc_r[TERMS].side;

endmodule

>>> hw/rtl/ssr_norm.sv
// ----------------------------------------------------------------------------
// Sigmoid output scaling
// Computes M*p/(1+e) with round to nearest by a pipelined long division.
// ----------------------------------------------------------------------------
module ssr_norm (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [ssr_pkg::S_W-1:0] in_s,
  input  logic [ssr_pkg::K_W-1:0] in_k,
  input  ssr_pkg::ssr_side_t      in_side,
  output logic                    out_valid,
  output ssr_pkg::ssr_out_t       out_item
);
  import ssr_pkg::*;

  localparam int P_W  = DATA_W + S_W;
  localparam int RW   = P_W + 1;
  localparam int DD_W = Q_FRAC + 2;
  localparam logic [S_W-1:0] S_ONE = S_W'(1) << Q_FRAC;

  logic              ev_r;
  logic [S_W-1:0]    e_r;
  ssr_side_t         eside_r;
  logic [S_W-1:0]    p;
  logic [DD_W-1:0]   dd_nxt;
  logic [P_W-1:0]    prod_nxt;

  logic              dv_r    [0:DATA_W];
  logic [RW-1:0]     drem_r  [0:DATA_W];
  logic [DATA_W-1:0] dquo_r  [0:DATA_W];
  logic [DD_W-1:0]   ddd_r   [0:DATA_W];
  ssr_side_t         dside_r [0:DATA_W];
  logic [RW-1:0]     drem_nxt [0:DATA_W-1];
  logic              dtake    [0:DATA_W-1];

  logic              rnd;
  logic [DATA_W:0]   qr;
  ssr_out_t          out_nxt;
  logic              ov_r;
  ssr_out_t          out_r;

  assign p        = eside_r.neg ? S_ONE : e_r;
  assign dd_nxt   = DD_W'(S_ONE) + DD_W'(e_r);
  assign prod_nxt = P_W'(eside_r.m) * P_W'(p);

  for (genvar j = 0; j < DATA_W; j++) begin : g_div
    logic [RW-1:0] dvs;
    assign dvs         = RW'(ddd_r[j]) << (DATA_W - 1 - j);
    assign dtake[j]    = (drem_r[j] >= dvs);
    assign drem_nxt[j] = dtake[j] ? (drem_r[j] - dvs) : drem_r[j];
  end

  assign rnd = ((drem_r[DATA_W] << 1) >= RW'(ddd_r[DATA_W]));
  assign qr  = (DATA_W + 1)'(dquo_r[DATA_W]) + (DATA_W + 1)'(rnd);

  always_comb begin
    out_nxt.last_out = dside_r[DATA_W].last;
    if (dside_r[DATA_W].zero) begin
      out_nxt.rate_out = '0;
    end else if (qr[DATA_W]) begin
      out_nxt.rate_out = '1;
    end else begin
      out_nxt.rate_out = qr[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= 1'b0;
      ov_r <= 1'b0;
      for (int i = 0; i <= DATA_W; i++) dv_r[i] <= 1'b0;
    end else begin
      ev_r    <= in_valid;
      dv_r[0] <= ev_r;
      for (int i = 0; i < DATA_W; i++) dv_r[i + 1] <= dv_r[i];
      ov_r    <= dv_r[DATA_W];
    end
    e_r        <= in_s >> in_k;
    eside_r    <= in_side;
    drem_r[0]  <= RW'(prod_nxt);
    dquo_r[0]  <= '0;
    ddd_r[0]   <= dd_nxt;
    dside_r[0] <= eside_r;
    for (int i = 0; i < DATA_W; i++) begin
      drem_r[i + 1]  <= drem_nxt[i];
      dquo_r[i + 1]  <= {dquo_r[i][DATA_W-2:0], dtake[i]};
      ddd_r[i + 1]   <= ddd_r[i];
      dside_r[i + 1] <= dside_r[i];
    end
    out_r <= out_nxt;
  end

  assign out_valid = ov_r;
  assign out_item  = out_r;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Scaled sigmoid rate unit testbench
// Drives samples through the sigmoid pipeline under several ceiling and slope
// settings, predicts each rate in fixed point and checks every result transfer
// in order against the predicted rate and last marker.
// ----------------------------------------------------------------------------
module tb;
  import ssr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = LATENCY + 20;
  localparam int CYCLE_LIMIT  = 600000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  ssr_in_t           in_data = '0;
  logic              out_valid;
  ssr_out_t          out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_OUTPUT;
  logic [DATA_W-1:0] cfg_wdata = '0;

  logic [DATA_W-1:0] ceiling_q = 16'd256;
  logic [DATA_W-1:0] slope_q = 16'd256;
  ssr_out_t          rate_queue[$];
  bit                failed = 1'b0;
  bit                steady = 1'b0;
  int                cycles = 0;

  scaled_sigmoid_rate_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned exp_neg(longint unsigned u);
    longint unsigned ln2, k, r, s;
    ln2 = 64'd2977044472;
    k = u / ln2;
    r = u - k * ln2;
    s = 64'd1 << 32;
    for (int n = TERMS; n >= 1; n--) begin
      s = (64'd1 << 32) - ((r * s) >> 32) / longint'(n);
    end
    if (k >= 63) return 0;
    return s >> k;
  endfunction

  function automatic logic [DATA_W-1:0] sigmoid_rate(logic [DATA_W-1:0] ceil_v,
                                                     logic [DATA_W-1:0] slope_v,
                                                     logic [DATA_W-1:0] x_v);
    longint a, x, d, mm;
    longint unsigned m, amag, dmag, num, den, u, ip, r, fr, e, p, dd, q, rem;
    bit neg;
    m = ceil_v;
    if (m == 0) return '0;
    mm = longint'(m);
    a = longint'($signed(slope_v));
    x = longint'($signed(x_v));
    d = mm - 2 * x;
    neg = (a < 0) != (d < 0);
    amag = (a < 0) ? -a : a;
    dmag = (d < 0) ? -d : d;
    num = amag * dmag;
    den = m << (FRAC_W + 1);
    if (num == 0) neg = 1'b0;
    if (num / den >= 32) begin
      u = 64'd32 << 32;
    end else begin
      ip = num / den;
      r = num - ip * den;
      fr = 0;
      for (int i = 0; i < 32; i++) begin
        r = r << 1;
        fr = fr << 1;
        if (r >= den) begin
          r = r - den;
          fr = fr | 1;
        end
      end
      u = (ip << 32) | fr;
    end
    e = exp_neg(u);
    p = neg ? (64'd1 << 32) : e;
    dd = (64'd1 << 32) + e;
    q = (m * p) / dd;
    rem = m * p - q * dd;
    if (rem * 2 >= dd) q++;
    return (q > 64'hFFFF) ? 16'hFFFF : q[DATA_W-1:0];
  endfunction

  // Expected results are formed from the transfer seen at the clock edge.
  always @(posedge clk) begin
    ssr_out_t exp_r;
    if (rst_n && start && !busy) begin
      exp_r.rate_out = sigmoid_rate(ceiling_q, slope_q, in_data.sample_in);
      exp_r.last_out = in_data.last_in;
      rate_queue.push_back(exp_r);
    end
  end

  always @(posedge clk) begin
    ssr_out_t exp_r;
    if (rst_n && out_valid) begin
      if (rate_queue.size() == 0) begin
        $display("%0t: unexpected result rate=%h last=%b", $time,
                 out_data.rate_out, out_data.last_out);
        failed = 1'b1;
      end else begin
        exp_r = rate_queue.pop_front();
        if (exp_r.rate_out !== out_data.rate_out) begin
          $display("%0t: rate mismatch expected=%h actual=%h", $time,
                   exp_r.rate_out, out_data.rate_out);
          failed = 1'b1;
        end
        if (exp_r.last_out !== out_data.last_out) begin
          $display("%0t: last mismatch expected=%b actual=%b", $time,
                   exp_r.last_out, out_data.last_out);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_sample(logic [DATA_W-1:0] x, logic last);
    bit taken;
    while (!steady && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data.sample_in <= x;
    in_data.last_in <= last;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (rate_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_OUTPUT) ceiling_q = val;
    else slope_q = val;
  endtask

  task automatic set_curve(logic [DATA_W-1:0] ceil_v, logic [DATA_W-1:0] slope_v);
    settle();
    write_reg(REG_MAX_OUTPUT, ceil_v);
    write_reg(REG_SLOPE_GAIN, slope_v);
  endtask

  task automatic test_directed_extremes();
    logic [DATA_W-1:0] pts[$];
    pts = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h0080,
            16'h0100, 16'h0200, 16'hFF00, 16'h5555, 16'hAAAA};
    foreach (pts[i]) send_sample(pts[i], i[0]);
    set_curve(16'hFFFF, 16'h7FFF);
    foreach (pts[i]) send_sample(pts[i], i[0]);
    set_curve(16'h0001, 16'h8000);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0001, 1'b0);
  endtask

  task automatic test_zero_ceiling();
    set_curve(16'h0000, 16'h0100);
    send_sample(16'h0080, 1'b1);
    send_sample(16'h8000, 1'b0);
  endtask

  task automatic test_zero_slope();
    set_curve(16'h0200, 16'h0000);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0100, 1'b1);
  endtask

  task automatic run_random_phase(int count);
    logic [DATA_W-1:0] x;
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3) && (i < count / 2);
      if ($urandom_range(3) == 0)
        x = DATA_W'(ceiling_q / 2 + $urandom_range(64) - 32);
      else
        x = DATA_W'($urandom);
      send_sample(x, 1'($urandom_range(1)));
    end
    steady = 1'b0;
  endtask

  task automatic test_random_curves();
    run_random_phase(300);
    set_curve(16'hFFFF, 16'h8000);
    run_random_phase(250);
    set_curve(16'h0400, 16'h0800);
    run_random_phase(250);
    for (int p = 0; p < 5; p++) begin
      set_curve(DATA_W'($urandom_range(65535, 1)), DATA_W'($urandom));
      run_random_phase(200);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_zero_ceiling();
    test_zero_slope();
    set_curve(16'd256, 16'd256);
    test_random_curves();
    settle();
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ssr_pkg.sv
hw/rtl/ssr_expo.sv
hw/rtl/ssr_exp.sv
hw/rtl/ssr_norm.sv
hw/rtl/scaled_sigmoid_rate_unit.sv
test/tb.sv
